FILE: rtl/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// shared widths, operation codes and status codes of the vector unit
// ----------------------------------------------------------------------------
package vau_pkg;

  // value format: signed fixed point, VALUE_W bits with FRAC_BITS fraction
  localparam int VALUE_W  = 32;
  localparam int FRAC_BITS = 16;

  // square root of a sum of squares, one result bit per stage
  localparam int ROOT_W     = VALUE_W;
  localparam int RAD_W      = 2 * VALUE_W;
  localparam int SQRT_STEPS = ROOT_W;

  // restoring divider, one quotient bit per stage
  localparam int NUM_W     = VALUE_W + FRAC_BITS;
  localparam int DEN_W     = VALUE_W;
  localparam int DIV_STEPS = NUM_W;

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_DOT   = 3'd2;
  localparam logic [2:0] OP_CROSS = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

endpackage

FILE: rtl/vau_sqrt.sv
// ----------------------------------------------------------------------------
// vau_sqrt
// pipelined integer square root, floor of the root, one bit per stage
// ----------------------------------------------------------------------------
module vau_sqrt import vau_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_in,
  output logic [ROOT_W-1:0] root_out
);

  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RAD_W-1:0]  c_rad;
    logic [REM_W-1:0]  c_rem;
    logic [ROOT_W-1:0] c_root;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign c_rad  = rad_in;
      assign c_rem  = '0;
      assign c_root = '0;
    end else begin : g_next
      assign c_rad  = rad_q[k-1];
      assign c_rem  = rem_q[k-1];
      assign c_root = root_q[k-1];
    end

    // bring down the next two radicand bits and try 4*root+1
    assign t     = {c_rem, c_rad[RAD_W-1 -: 2]};
    assign trial = (REM_W + 2)'({c_root, 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= c_rad << 2;
        rem_q[k]  <= ge ? REM_W'(t - trial) : REM_W'(t);
        root_q[k] <= {c_root[ROOT_W-2:0], ge};
      end
    end
  end

  assign root_out = root_q[SQRT_STEPS-1];

endmodule

FILE: rtl/vau_div.sv
// ----------------------------------------------------------------------------
// vau_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vau_div import vau_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [NUM_W-1:0] quo_out
);

  logic [NUM_W-1:0] n_q   [DIV_STEPS];
  logic [DEN_W-1:0] rem_q [DIV_STEPS];
  logic [NUM_W-1:0] q_q   [DIV_STEPS];
  logic [DEN_W-1:0] d_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [NUM_W-1:0] c_n;
    logic [DEN_W-1:0] c_rem;
    logic [NUM_W-1:0] c_q;
    logic [DEN_W-1:0] c_d;
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign c_n   = num_in;
      assign c_rem = '0;
      assign c_q   = '0;
      assign c_d   = den_in;
    end else begin : g_next
      assign c_n   = n_q[k-1];
      assign c_rem = rem_q[k-1];
      assign c_q   = q_q[k-1];
      assign c_d   = d_q[k-1];
    end

    assign t    = {c_rem, c_n[NUM_W-1]};
    assign diff = t - {1'b0, c_d};
    assign ge   = (t >= {1'b0, c_d});

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k]   <= c_n << 1;
        rem_q[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        q_q[k]   <= {c_q[NUM_W-2:0], ge};
        d_q[k]   <= c_d;
      end
    end
  end

  assign quo_out = q_q[DIV_STEPS-1];

endmodule

FILE: rtl/vec3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vec3_arithmetic_unit
// three-component fixed-point vector unit: add, subtract, dot, cross,
// divide by scalar and normalise, with saturation and status
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall with op, a_x..a_z, b_x..b_z
//   result channel:  res_valid / res_stall with r_x..r_z, r_scalar, status
//   an item is taken on a rising edge with valid high and stall low
// pipeline and throughput
//   every operation takes the same path, so results leave in order
//   84 register stages, 3 + 32 + 48 + 1: the input register, multiply,
//   sum and saturate, a 32-stage square root (one root bit per stage), a
//   48-stage divider (one quotient bit per stage, three lanes) and the
//   output register
//   one item per cycle is accepted while the receiver keeps up
// stall
//   when the output holds an item and res_stall is high the whole pipe
//   freezes and req_stall rises; nothing is lost or repeated
// reset
//   rst (synchronous) clears every valid bit; data registers keep contents
// ----------------------------------------------------------------------------
module vec3_arithmetic_unit import vau_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [2:0]                op,
  input  logic signed [VALUE_W-1:0] a_x,
  input  logic signed [VALUE_W-1:0] a_y,
  input  logic signed [VALUE_W-1:0] a_z,
  input  logic signed [VALUE_W-1:0] b_x,
  input  logic signed [VALUE_W-1:0] b_y,
  input  logic signed [VALUE_W-1:0] b_z,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [VALUE_W-1:0] r_x,
  output logic signed [VALUE_W-1:0] r_y,
  output logic signed [VALUE_W-1:0] r_z,
  output logic signed [VALUE_W-1:0] r_scalar,
  output logic [1:0]                status
);

  localparam int PROD_W = 2 * VALUE_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((66'sd1 <<< (VALUE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - 1;
  localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(66'sd1 <<< (FRAC_BITS - 1));
  localparam logic [NUM_W-1:0] QPOS_MAX = NUM_W'((64'd1 << (VALUE_W - 1)) - 1);
  localparam logic [NUM_W-1:0] QNEG_MAX = NUM_W'(64'd1 << (VALUE_W - 1));
  localparam logic signed [VALUE_W-1:0] VMAX = VALUE_W'((64'd1 << (VALUE_W - 1)) - 1);
  localparam logic signed [VALUE_W-1:0] VMIN = ~VMAX;

  // sideband that travels alongside the square root and divider stages
  typedef struct packed {
    logic [2:0]                  op;
    logic [2:0][VALUE_W-1:0]     a;
    logic [VALUE_W-1:0]          bx;
    logic [2:0][VALUE_W-1:0]     r;
    logic [VALUE_W-1:0]          sc;
    logic [1:0]                  st;
    logic [2:0]                  neg;
    logic                        dz;
  } side_t;

  // saturate a wide signed value, flag in the top bit
  function automatic logic [VALUE_W:0] sat_wide(input logic signed [SUM_W-1:0] v);
    logic [VALUE_W:0] res;
    if (v > SUM_MAX) begin
      res = {1'b1, VMAX};
    end else if (v < SUM_MIN) begin
      res = {1'b1, VMIN};
    end else begin
      res = {1'b0, v[VALUE_W-1:0]};
    end
    return res;
  endfunction

  // round to nearest (ties up), drop the fraction, saturate
  function automatic logic [VALUE_W:0] rnd_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    return sat_wide(t);
  endfunction

  // apply the sign to a quotient magnitude and saturate
  function automatic logic [VALUE_W:0] quo_sat(input logic [NUM_W-1:0] q, input logic neg);
    logic [VALUE_W:0]   res;
    logic [NUM_W-1:0]   nq;
    nq = -q;
    if (neg) begin
      if (q > QNEG_MAX) res = {1'b1, VMIN};
      else              res = {1'b0, nq[VALUE_W-1:0]};
    end else begin
      if (q > QPOS_MAX) res = {1'b1, VMAX};
      else              res = {1'b0, q[VALUE_W-1:0]};
    end
    return res;
  endfunction

  // whole pipe advances together unless the output item is held
  logic en;
  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  // ---------------- stage 1: input register ----------------
  logic                       v1;
  logic [2:0]                 op1;
  logic signed [VALUE_W-1:0]  a1 [3];
  logic signed [VALUE_W-1:0]  b1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
    if (en) begin
      op1   <= op;
      a1[0] <= a_x;
      a1[1] <= a_y;
      a1[2] <= a_z;
      b1[0] <= b_x;
      b1[1] <= b_y;
      b1[2] <= b_z;
    end
  end

  // ---------------- stage 2: products and sums ----------------
  // six shared multipliers: dot and normalise use the first three,
  // cross uses all six
  logic signed [VALUE_W-1:0] ma [6];
  logic signed [VALUE_W-1:0] mb [6];
  logic                      is_cross1;
  logic                      is_norm1;

  assign is_cross1 = (op1 == OP_CROSS);
  assign is_norm1  = (op1 == OP_NORM);

  always_comb begin
    ma[0] = is_cross1 ? a1[1] : a1[0];
    mb[0] = is_cross1 ? b1[2] : (is_norm1 ? a1[0] : b1[0]);
    ma[1] = is_cross1 ? a1[2] : a1[1];
    mb[1] = is_cross1 ? b1[1] : (is_norm1 ? a1[1] : b1[1]);
    ma[2] = a1[2];
    mb[2] = is_cross1 ? b1[0] : (is_norm1 ? a1[2] : b1[2]);
    ma[3] = a1[0];
    mb[3] = b1[2];
    ma[4] = a1[0];
    mb[4] = b1[1];
    ma[5] = a1[1];
    mb[5] = b1[0];
  end

  logic                      v2;
  logic [2:0]                op2;
  logic signed [VALUE_W-1:0] a2 [3];
  logic signed [VALUE_W-1:0] bx2;
  logic signed [PROD_W-1:0]  p2 [6];
  logic signed [VALUE_W:0]   s2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2 <= op1;
      bx2 <= b1[0];
      for (int i = 0; i < 6; i++) begin
        p2[i] <= ma[i] * mb[i];
      end
      for (int i = 0; i < 3; i++) begin
        a2[i] <= a1[i];
        s2[i] <= (op1 == OP_SUB) ? (VALUE_W+1)'(a1[i]) - (VALUE_W+1)'(b1[i])
                                 : (VALUE_W+1)'(a1[i]) + (VALUE_W+1)'(b1[i]);
      end
    end
  end

  // ---------------- stage 3: rounding, saturation, radicand ----------------
  side_t            side3_next;
  logic [RAD_W-1:0] rad3_next;
  logic [VALUE_W:0] fx [3];
  logic [VALUE_W:0] fdot;

  always_comb begin
    side3_next.op  = op2;
    side3_next.bx  = bx2;
    side3_next.neg = '0;
    side3_next.dz  = 1'b0;
    side3_next.r   = '0;
    side3_next.sc  = '0;
    side3_next.st  = ST_OK;
    for (int i = 0; i < 3; i++) begin
      side3_next.a[i] = a2[i];
    end
    fdot  = rnd_sat(SUM_W'(p2[0]) + SUM_W'(p2[1]) + SUM_W'(p2[2]));
    fx[0] = rnd_sat(SUM_W'(p2[0]) - SUM_W'(p2[1]));
    fx[1] = rnd_sat(SUM_W'(p2[2]) - SUM_W'(p2[3]));
    fx[2] = rnd_sat(SUM_W'(p2[4]) - SUM_W'(p2[5]));
    case (op2)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          fx[i] = sat_wide(SUM_W'(s2[i]));
        end
        for (int i = 0; i < 3; i++) begin
          side3_next.r[i] = fx[i][VALUE_W-1:0];
        end
        if (fx[0][VALUE_W] || fx[1][VALUE_W] || fx[2][VALUE_W]) side3_next.st = ST_SAT;
      end
      OP_DOT: begin
        side3_next.sc = fdot[VALUE_W-1:0];
        if (fdot[VALUE_W]) side3_next.st = ST_SAT;
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          side3_next.r[i] = fx[i][VALUE_W-1:0];
        end
        if (fx[0][VALUE_W] || fx[1][VALUE_W] || fx[2][VALUE_W]) side3_next.st = ST_SAT;
      end
      default: begin
      end
    endcase
    // squares are never negative, so the plain sum is the radicand
    rad3_next = RAD_W'(p2[0]) + RAD_W'(p2[1]) + RAD_W'(p2[2]);
  end

  logic             v3;
  side_t            side3;
  logic [RAD_W-1:0] rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      side3 <= side3_next;
      rad3  <= rad3_next;
    end
  end

  // ---------------- square root stages ----------------
  logic [ROOT_W-1:0] root;
  logic              vsq   [SQRT_STEPS];
  side_t             sidesq [SQRT_STEPS];

  vau_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (rad3),
    .root_out (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_STEPS; i++) vsq[i] <= 1'b0;
    end else if (en) begin
      vsq[0] <= v3;
      for (int i = 1; i < SQRT_STEPS; i++) vsq[i] <= vsq[i-1];
    end
    if (en) begin
      sidesq[0] <= side3;
      for (int i = 1; i < SQRT_STEPS; i++) sidesq[i] <= sidesq[i-1];
    end
  end

  // ---------------- divider entry ----------------
  side_t              sq_out;
  side_t              side_dv_in;
  logic               is_div;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   num [3];
  logic [VALUE_W-1:0] bx_abs;
  logic [VALUE_W-1:0] a_abs [3];

  assign sq_out = sidesq[SQRT_STEPS-1];
  assign is_div = (sq_out.op == OP_DIV);
  assign bx_abs = sq_out.bx[VALUE_W-1] ? -sq_out.bx : sq_out.bx;
  assign den    = is_div ? bx_abs : root;

  always_comb begin
    side_dv_in    = sq_out;
    side_dv_in.dz = (den == '0);
    for (int i = 0; i < 3; i++) begin
      a_abs[i]          = sq_out.a[i][VALUE_W-1] ? -sq_out.a[i] : sq_out.a[i];
      num[i]            = {a_abs[i], {FRAC_BITS{1'b0}}};
      side_dv_in.neg[i] = sq_out.a[i][VALUE_W-1] ^ (is_div & sq_out.bx[VALUE_W-1]);
    end
  end

  // ---------------- divider stages, one lane per component ----------------
  logic [NUM_W-1:0] quo [3];
  logic             vdv    [DIV_STEPS];
  side_t            sidedv [DIV_STEPS];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vau_div u_div (
      .clk     (clk),
      .en      (en),
      .num_in  (num[l]),
      .den_in  (den),
      .quo_out (quo[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STEPS; i++) vdv[i] <= 1'b0;
    end else if (en) begin
      vdv[0] <= vsq[SQRT_STEPS-1];
      for (int i = 1; i < DIV_STEPS; i++) vdv[i] <= vdv[i-1];
    end
    if (en) begin
      sidedv[0] <= side_dv_in;
      for (int i = 1; i < DIV_STEPS; i++) sidedv[i] <= sidedv[i-1];
    end
  end

  // ---------------- output stage ----------------
  side_t              dv_out;
  logic [VALUE_W:0]   fq [3];
  logic [VALUE_W-1:0] r_next [3];
  logic [VALUE_W-1:0] sc_next;
  logic [1:0]         st_next;

  assign dv_out = sidedv[DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fq[i]     = quo_sat(quo[i], dv_out.neg[i]);
      r_next[i] = dv_out.r[i];
    end
    sc_next = dv_out.sc;
    st_next = dv_out.st;
    if (dv_out.op == OP_DIV || dv_out.op == OP_NORM) begin
      sc_next = '0;
      if (dv_out.dz) begin
        for (int i = 0; i < 3; i++) r_next[i] = '0;
        st_next = ST_DIVZ;
      end else begin
        for (int i = 0; i < 3; i++) r_next[i] = fq[i][VALUE_W-1:0];
        st_next = (fq[0][VALUE_W] || fq[1][VALUE_W] || fq[2][VALUE_W]) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vdv[DIV_STEPS-1];
    end
    if (en) begin
      r_x      <= r_next[0];
      r_y      <= r_next[1];
      r_z      <= r_next[2];
      r_scalar <= sc_next;
      status   <= st_next;
    end
  end

endmodule
